>>> rtl/core/bitmap_find_next_bit_assert.svh
// Assertion macros for the bitmap find-next-bit block.
`ifndef BITMAP_FIND_NEXT_BIT_ASSERT_SVH
`define BITMAP_FIND_NEXT_BIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define BFNB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BFNB_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/bfnb_pkg.sv
// Shared types and constants of the bitmap find-next-bit block.
package bfnb_pkg;

  localparam int OP_W      = 2;
  localparam int INDEX_W   = 6;
  localparam int DATA_W    = 64;
  localparam int START_W   = 12;
  localparam int BIT_POS_W = 13;

  localparam logic [BIT_POS_W-1:0] BIT_COUNT_RST = 13'd4096;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND_ZERO = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // zero one memory word during the reset sweep
    logic write;  // store a bitmap word
    logic load;   // capture a query
    logic div;    // starting word from start bit
    logic offs;   // word base, bit offset, first read
    logic scan;   // test one word, read the next
    logic enc;    // encode and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic early_miss;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/bfnb_ctrl.sv
// Controller state machine of the bitmap find-next-bit block.
module bfnb_ctrl
  import bfnb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] operation_i,
  input  status_t         status_i,
  output logic            in_stall_o,
  output cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_OFFS  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_ENC   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (operation_i)
            OP_WRITE: begin
              cmd_o.write = 1'b1;
            end
            OP_FIND_SET, OP_FIND_ZERO: begin
              cmd_o.load = 1'b1;
              state_d    = status_i.early_miss ? S_ENC : S_DIV;
            end
            default: ;  // unused code, dropped
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_OFFS;
      end
      S_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_hit || status_i.scan_end) begin
          state_d = S_ENC;
        end
      end
      S_ENC: begin
        if (status_i.out_free) begin
          cmd_o.enc = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/bfnb_dp.sv
// Datapath of the bitmap find-next-bit block: word memory, scan and result register.
module bfnb_dp
  import bfnb_pkg::*;
#(
  parameter int WORD_COUNT = 64,
  parameter int WORD_BITS  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 cfg_we_i,
  input  logic [BIT_POS_W-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [INDEX_W-1:0]   word_index_i,
  input  logic [DATA_W-1:0]    word_data_i,
  input  logic [START_W-1:0]   start_bit_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BIT_POS_W-1:0] bit_position_o,
  output logic                 not_found_o
);

  localparam int AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OFFW  = $clog2(WORD_BITS);
  localparam int CAP   = WORD_COUNT * WORD_BITS;
  localparam int PW    = $clog2(CAP + WORD_BITS + 1);
  // reciprocal of WORD_BITS, exact for any 12-bit start bit
  localparam int RSH   = 20;
  localparam int RECIP = (2 ** RSH + WORD_BITS - 1) / WORD_BITS;

  logic [WORD_BITS-1:0] mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_q;
  logic [AW-1:0]        clr_q;

  logic [BIT_POS_W-1:0] bit_count_q;
  logic [START_W-1:0]   start_q;
  logic                 inv_q;
  logic [PW-1:0]        limit_q, limit_d;
  logic [AW-1:0]        w_q;
  logic [PW-1:0]        base_q;
  logic [OFFW-1:0]      off_q;
  logic                 first_q;
  logic                 hit_q;
  logic [WORD_BITS-1:0] iso_q;

  logic                 out_valid_q;
  logic [BIT_POS_W-1:0] bit_position_q;
  logic                 not_found_q;

  logic [31:0]          quot_prod;
  logic [PW-1:0]        base_d;
  logic [PW-1:0]        next_base;
  logic [WORD_BITS-1:0] word_v, mask_v, vec_v, iso_v;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 idx_ok;
  logic [OFFW-1:0]      low_idx;
  logic [PW-1:0]        pos;
  logic                 found;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= BIT_COUNT_RST;
    end else if (cfg_we_i) begin
      bit_count_q <= cfg_wdata_i;
    end
  end

  // ---- word memory: one write port, one registered read port ----
  assign idx_ok  = (32'(word_index_i) < WORD_COUNT);
  assign rd_en   = cmd_i.offs || (cmd_i.scan && (w_q != AW'(WORD_COUNT - 1)));
  assign rd_addr = cmd_i.offs ? w_q : w_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.write && idx_ok) begin
      mem_q[AW'(word_index_i)] <= word_data_i[WORD_BITS-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign status_o.clear_last = (clr_q == AW'(WORD_COUNT - 1));

  // ---- query capture ----
  assign limit_d = (32'(bit_count_q) >= CAP) ? PW'(CAP) : PW'(bit_count_q);
  assign status_o.early_miss = (limit_d == '0) || (32'(start_bit_i) >= 32'(limit_d));

  // ---- starting word and offset ----
  assign quot_prod = {{(32-START_W){1'b0}}, start_q} * 32'(RECIP);
  assign base_d    = PW'(32'(w_q) * WORD_BITS);

  // ---- word test ----
  assign word_v    = rdata_q ^ {WORD_BITS{inv_q}};
  assign mask_v    = first_q ? ({WORD_BITS{1'b1}} << off_q) : {WORD_BITS{1'b1}};
  assign vec_v     = word_v & mask_v;
  assign iso_v     = vec_v & (~vec_v + WORD_BITS'(1));
  assign next_base = base_q + PW'(WORD_BITS);

  assign status_o.scan_hit = (vec_v != '0);
  assign status_o.scan_end = (next_base >= limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= start_bit_i;
      inv_q   <= (operation_i == OP_FIND_ZERO);
      limit_q <= limit_d;
      hit_q   <= 1'b0;
    end
    if (cmd_i.div) begin
      w_q <= AW'(quot_prod >> RSH);
    end
    if (cmd_i.offs) begin
      base_q  <= base_d;
      off_q   <= OFFW'(32'(start_q) - 32'(base_d));
      first_q <= 1'b1;
    end
    if (cmd_i.scan) begin
      first_q <= 1'b0;
      if (status_o.scan_hit) begin
        hit_q <= 1'b1;
        iso_q <= iso_v;
      end else begin
        w_q    <= w_q + AW'(1);
        base_q <= next_base;
      end
    end
  end

  // ---- encode: iso_q holds only the lowest matching bit ----
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso_q[i]) begin
        low_idx = low_idx | OFFW'(i);
      end
    end
  end

  assign pos   = base_q + PW'(low_idx);
  assign found = hit_q && (pos < limit_q);

  // ---- result register ----
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.enc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enc) begin
      bit_position_q <= found ? BIT_POS_W'(pos) : bit_count_q;
      not_found_q    <= !found;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bit_position_o = bit_position_q;
  assign not_found_o    = not_found_q;

endmodule

>>> rtl/core/bitmap_find_next_bit.sv
// Top level of the bitmap find-next-bit block.
// The block keeps a bitmap of WORD_COUNT words of WORD_BITS bits and answers
// find-next-set and find-next-zero queries from a start bit (start 0 gives
// find-first). A write transaction (operation 0) stores word_data_i at
// word_index_i and returns nothing; indexes at or past WORD_COUNT are
// dropped, as is operation code 3. A query (operation 1 or 2) returns one
// result: the lowest matching bit position below bit_count, or bit_count
// with not_found_o high. Bits at or past WORD_COUNT*WORD_BITS never match.
// An accepted query passes the states DIV, OFFS, SCAN and ENC; SCAN walks 1
// to WORD_COUNT words, one word per cycle, bounded by the single read port
// of the word memory. A query whose start bit is at or past bit_count, or
// with bit_count zero, goes from acceptance straight to ENC. One transaction
// is worked on at a time; the input stalls meanwhile, and a finished result
// waits in the output register while the next transaction is taken. After
// reset the memory is swept to zero word by word, with the input stalled;
// bit_count may be written at any time while idle, and resets to 4096.
`include "bitmap_find_next_bit_assert.svh"

module bitmap_find_next_bit
  import bfnb_pkg::*;
#(
  parameter int WORD_COUNT = 64,
  parameter int WORD_BITS  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: bit_count
  input  logic                 cfg_we_i,
  input  logic [BIT_POS_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [INDEX_W-1:0]   word_index_i,
  input  logic [DATA_W-1:0]    word_data_i,
  input  logic [START_W-1:0]   start_bit_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BIT_POS_W-1:0] bit_position_o,
  output logic                 not_found_o
);

  cmd_t    cmd;
  status_t status;

  bfnb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  bfnb_dp #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .word_index_i   (word_index_i),
    .word_data_i    (word_data_i),
    .start_bit_i    (start_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bit_position_o (bit_position_o),
    .not_found_o    (not_found_o)
  );

  // the reset sweep owns the memory write port, so the input must stall
  `BFNB_ASSERT(a_clear_stalls, clk_i, rst_ni, cmd.clear |-> in_stall_o, "input taken during clear")
  // a pending result is never overwritten
  `BFNB_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.enc && out_valid_o && out_stall_i,
    "result overwritten while stalled")
  // the controller issues at most one command per cycle
  `BFNB_ASSERT(a_one_cmd, clk_i, rst_ni,
    $onehot0({cmd.clear, cmd.write, cmd.load, cmd.div, cmd.offs, cmd.scan, cmd.enc}),
    "more than one datapath command")
  // a loaded result is shown in the cycle after it is loaded
  `BFNB_ASSERT(a_enc_shows, clk_i, rst_ni, cmd.enc |=> out_valid_o, "loaded result not valid")

endmodule
